FILE: rtl/core/qhm_pkg.sv
// shared types, widths and constants of the quasi-hyperbolic momentum update block
`timescale 1ns / 1ps
`default_nettype none

package qhm_pkg;

   localparam int DATA_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int FACT_W       = 17;
   localparam int IDX_W        = 12;
   localparam int ELEMENTS_DEF = 4096;

   localparam int REQ_W        = 80;
   localparam int RSP_W        = 48;
   localparam int CSR_IDX_W    = 8;

   localparam logic [FACT_W-1:0] ONE_Q        = 17'd65536;
   localparam logic [FACT_W-1:0] RST_LR       = 17'd66;
   localparam logic [FACT_W-1:0] RST_BETA     = 17'd58982;
   localparam logic [FACT_W-1:0] RST_NU       = 17'd45875;
   localparam logic [FACT_W-1:0] RST_DECAY    = 17'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE = 8'd0,
      CSR_BETA          = 8'd1,
      CSR_NU            = 8'd2,
      CSR_DECAY         = 8'd3
   } csr_index_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qhm_mom_store.sv
// momentum and seen-flag memory with read port, write port and clearing pass after reset
`timescale 1ns / 1ps
`default_nettype none

module qhm_mom_store #(
   parameter int ELEMENTS = qhm_pkg::ELEMENTS_DEF
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          rd_en,
   input  wire  [qhm_pkg::addr_width(ELEMENTS)-1:0]     rd_addr,
   output logic                                         rd_seen,
   output logic signed [qhm_pkg::DATA_W-1:0]            rd_mom,
   input  wire                                          wr_en,
   input  wire  [qhm_pkg::addr_width(ELEMENTS)-1:0]     wr_addr,
   input  wire  [qhm_pkg::DATA_W-1:0]                   wr_mom,
   output logic                                         busy
);

   localparam int AW = qhm_pkg::addr_width(ELEMENTS);
   localparam int MW = qhm_pkg::DATA_W + 1;

   logic [MW-1:0] store_ff [ELEMENTS];
   logic [MW-1:0] rd_q_ff;
   logic          busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          we;
   logic [AW-1:0] wa;
   logic [MW-1:0] wd;

   // clearing pass owns the write port until every seen flag is zero
   always_comb begin
      if (busy_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end else begin
         we = wr_en;
         wa = wr_addr;
         wd = {1'b1, wr_mom};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(ELEMENTS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rd_seen = rd_q_ff[MW-1];
   assign rd_mom  = rd_q_ff[MW-2:0];
   assign busy    = busy_ff;

endmodule

`default_nettype wire

FILE: rtl/core/qhm_optimizer_update.sv
// top level of the element-wise quasi-hyperbolic momentum optimizer step
// usage:
//  req_* carries one element word: index, parameter and gradient, the last two Q16.16
//  rsp_* returns one word per element: the index and the saturated new parameter
//  csr_* writes learning_rate (0), beta (1), nu (2) and decay (3), Q1.16;
//  values above 1.0 are held at 1.0, unknown indexes are dropped
//  an accepted word passes stages 1 to 5 and the output register on its way to rsp_tvalid
//  throughput is one word per cycle unless stalled, for repeated indexes too: the new momentum
//  is forwarded from the multiply stage straight into the next read of that entry
//  the pipeline is one read, one write momentum memory plus six register stages
//  after reset a clearing pass zeroes the seen flags, one entry per cycle,
//  over all ELEMENTS entries; req_tready stays low until it ends, csr writes are taken
//  while rsp_tvalid is high and rsp_tready low the whole pipeline holds
//  and req_tready drops with it
//  csr writes are meant to happen only while no word is in flight
`timescale 1ns / 1ps
`default_nettype none

module qhm_optimizer_update #(
   parameter int ELEMENTS = qhm_pkg::ELEMENTS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [qhm_pkg::REQ_W-1:0]        req_tdata,  // element_index, param_value, grad_value
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [qhm_pkg::RSP_W-1:0]        rsp_tdata,  // out_index, new_param
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [qhm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [qhm_pkg::FACT_W-1:0]       csr_wdata
);

   localparam int DW     = qhm_pkg::DATA_W;
   localparam int FW     = qhm_pkg::FACT_W;
   localparam int FR     = qhm_pkg::FRAC_W;
   localparam int IW     = qhm_pkg::IDX_W;
   localparam int AW     = qhm_pkg::addr_width(ELEMENTS);
   localparam int D_W    = DW + 1;
   localparam int PROD_W = FW + 1 + D_W;
   localparam int SUM_W  = PROD_W - FR;
   localparam int SPAN   = 1 << IW;

   function automatic logic signed [SUM_W-1:0] round_q(input logic signed [PROD_W-1:0] x);
      logic [PROD_W-1:0] s;
      s = x + (PROD_W'(1) << (FR - 1));
      return s[PROD_W-1:FR];
   endfunction

   function automatic logic signed [DW-1:0] sat_data(input logic signed [SUM_W-1:0] x);
      logic [SUM_W-DW:0] top;
      top = x[SUM_W-1:DW-1];
      if (top == '0 || top == '1) begin
         return x[DW-1:0];
      end else if (x[SUM_W-1]) begin
         return {1'b1, {(DW-1){1'b0}}};
      end else begin
         return {1'b0, {(DW-1){1'b1}}};
      end
   endfunction

   function automatic logic [FW-1:0] clamp_factor(input logic [FW-1:0] v);
      return (v > qhm_pkg::ONE_Q) ? qhm_pkg::ONE_Q : v;
   endfunction

   // configuration
   logic [FW-1:0] lr_ff, beta_ff, nu_ff, wd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= qhm_pkg::RST_LR;
         beta_ff <= qhm_pkg::RST_BETA;
         nu_ff   <= qhm_pkg::RST_NU;
         wd_ff   <= qhm_pkg::RST_DECAY;
      end else if (csr_valid) begin
         case (csr_index)
            qhm_pkg::CSR_LEARNING_RATE: begin
               lr_ff <= clamp_factor(csr_wdata);
            end
            qhm_pkg::CSR_BETA: begin
               beta_ff <= clamp_factor(csr_wdata);
            end
            qhm_pkg::CSR_NU: begin
               nu_ff <= clamp_factor(csr_wdata);
            end
            qhm_pkg::CSR_DECAY: begin
               wd_ff <= clamp_factor(csr_wdata);
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // flow control
   logic adv, accept, store_busy;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv && !store_busy;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= v4_ff;
         rsp_tvalid_ff <= v5_ff;
      end
   end

   // stage 1: input word
   logic [IW-1:0]          req_idx;
   logic signed [DW-1:0]   req_par, req_grd;
   logic [IW-1:0]          idx1_ff;
   logic signed [DW-1:0]   par1_ff, grd1_ff;
   logic [AW-1:0]          addr1;

   assign req_idx = req_tdata[IW-1:0];
   assign req_par = req_tdata[IW+DW-1:IW];
   assign req_grd = req_tdata[IW+2*DW-1:IW+DW];

   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff <= req_idx;
         par1_ff <= req_par;
         grd1_ff <= req_grd;
      end
   end

   // element index to memory address, index modulo ELEMENTS
   if (ELEMENTS >= SPAN) begin : g_direct
      assign addr1 = AW'(idx1_ff);
   end else begin : g_mod
      localparam int    SH    = 2 * IW;
      localparam int    RW    = SH + 1;
      localparam int    QW    = IW + RW;
      localparam longint RECIP = ((longint'(1) << SH) + ELEMENTS - 1) / ELEMENTS;
      logic [QW-1:0]   qprod;
      logic [IW-1:0]   quot_in, quot_ff;
      logic [2*IW-1:0] qe, rem;

      // reciprocal with 2*IW fraction bits is exact for every IW-bit index
      assign qprod   = QW'(req_idx) * QW'(RECIP);
      assign quot_in = qprod[SH+IW-1:SH];

      always_ff @(posedge clock) begin
         if (adv) begin
            quot_ff <= quot_in;
         end
      end

      assign qe    = (2*IW)'(quot_ff) * (2*IW)'(ELEMENTS);
      assign rem   = (2*IW)'(idx1_ff) - qe;
      assign addr1 = rem[AW-1:0];
   end

   // stage 2: address, decay product, memory read in flight
   logic [IW-1:0]            idx2_ff;
   logic signed [DW-1:0]     par2_ff, grd2_ff;
   logic [AW-1:0]            addr2_ff;
   logic signed [PROD_W-1:0] wdp_in, wdp2_ff;
   logic                     rd_seen;
   logic signed [DW-1:0]     rd_mom;

   assign wdp_in = $signed({1'b0, wd_ff}) * par1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         idx2_ff  <= idx1_ff;
         par2_ff  <= par1_ff;
         grd2_ff  <= grd1_ff;
         addr2_ff <= addr1;
         wdp2_ff  <= wdp_in;
      end
   end

   // stage 3: decayed gradient, old momentum with forwarding
   logic [IW-1:0]          idx3_ff, idx4_ff, idx5_ff;
   logic signed [DW-1:0]   par3_ff, par4_ff, par5_ff;
   logic [AW-1:0]          addr3_ff, addr4_ff, addr5_ff;
   logic signed [DW-1:0]   g3_ff, g4_ff, mo3_ff, m4_ff, m5_ff, u5_ff;
   logic                   seen3_ff;
   logic signed [SUM_W-1:0] g_sum, m_sum, u_sum, p_sum;
   logic signed [DW-1:0]   g_in, m_in, u_in, mo_in, mold, np_in;
   logic                   seen_in;
   logic signed [D_W-1:0]  dm, du;
   logic signed [PROD_W-1:0] bprod, nprod, lprod;

   assign g_sum = SUM_W'(grd2_ff) + round_q(wdp2_ff);
   assign g_in  = sat_data(g_sum);

   // youngest in-flight write to the same entry wins
   always_comb begin
      if (v3_ff && addr3_ff == addr2_ff) begin
         seen_in = 1'b1;
         mo_in   = m_in;
      end else if (v4_ff && addr4_ff == addr2_ff) begin
         seen_in = 1'b1;
         mo_in   = m4_ff;
      end else if (v5_ff && addr5_ff == addr2_ff) begin
         seen_in = 1'b1;
         mo_in   = m5_ff;
      end else begin
         seen_in = rd_seen;
         mo_in   = rd_mom;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx3_ff  <= idx2_ff;
         par3_ff  <= par2_ff;
         addr3_ff <= addr2_ff;
         g3_ff    <= g_in;
         seen3_ff <= seen_in;
         mo3_ff   <= mo_in;
      end
   end

   // stage 4: new momentum = g + beta * (m - g)
   assign mold  = seen3_ff ? mo3_ff : g3_ff;
   assign dm    = D_W'(mold) - D_W'(g3_ff);
   assign bprod = $signed({1'b0, beta_ff}) * dm;
   assign m_sum = SUM_W'(g3_ff) + round_q(bprod);
   assign m_in  = m_sum[DW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         idx4_ff  <= idx3_ff;
         par4_ff  <= par3_ff;
         addr4_ff <= addr3_ff;
         g4_ff    <= g3_ff;
         m4_ff    <= m_in;
      end
   end

   qhm_mom_store #(
      .ELEMENTS (ELEMENTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (addr1),
      .rd_seen (rd_seen),
      .rd_mom  (rd_mom),
      .wr_en   (v4_ff && adv),
      .wr_addr (addr4_ff),
      .wr_mom  (m4_ff),
      .busy    (store_busy)
   );

   // stage 5: update = g + nu * (m - g)
   assign du    = D_W'(m4_ff) - D_W'(g4_ff);
   assign nprod = $signed({1'b0, nu_ff}) * du;
   assign u_sum = SUM_W'(g4_ff) + round_q(nprod);
   assign u_in  = u_sum[DW-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         idx5_ff  <= idx4_ff;
         par5_ff  <= par4_ff;
         addr5_ff <= addr4_ff;
         m5_ff    <= m4_ff;
         u5_ff    <= u_in;
      end
   end

   // output word: param - lr * update, saturated
   logic [IW-1:0]        rsp_idx_ff;
   logic signed [DW-1:0] rsp_par_ff;

   assign lprod = $signed({1'b0, lr_ff}) * u5_ff;
   assign p_sum = SUM_W'(par5_ff) - round_q(lprod);
   assign np_in = sat_data(p_sum);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_idx_ff <= idx5_ff;
         rsp_par_ff <= np_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(qhm_pkg::RSP_W-IW-DW){1'b0}}, rsp_par_ff, rsp_idx_ff};

`ifndef SYNTHESIS
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_tready)
      else $error("word accepted during clearing pass");

   a_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || rsp_tvalid_ff))
      else $error("pipeline busy during clearing pass");

   a_last_stage_flows: assert property (@(posedge clock) disable iff (reset)
      (adv && v5_ff) |=> rsp_tvalid_ff)
      else $error("word lost before output register");

   a_stall_holds_write: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !adv) |=> (v4_ff && $stable(addr4_ff) && $stable(m4_ff)))
      else $error("momentum write stage moved during stall");
`endif

endmodule

`default_nettype wire
